/* rtl/dupd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_pkg
// Types, constants and character helpers for the data URI payload decoder.
// ----------------------------------------------------------------------------
package dupd_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_META    = 3'd1,
    PH_B64     = 3'd2,
    PH_PCT     = 3'd3,
    PH_B64_END = 3'd4,
    PH_SINK    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_stage_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PREFIX = 2'd1;
  localparam logic [1:0] ST_NO_COMMA  = 2'd2;
  localparam logic [1:0] ST_BAD_B64   = 2'd3;

  localparam logic [2:0] PREFIX_LEN = 3'd5;
  localparam logic [2:0] TAG_LEN    = 3'd7;

  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic signed [3:0] BIT_CNT_INIT = -4'sd8;
  localparam logic signed [3:0] B64_BITS     = 4'sd6;
  localparam logic signed [3:0] BYTE_BITS    = 4'sd8;

  // one queue entry: bytes a character produced, then maybe the status item
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_status;
    logic [1:0]      status;
  } bundle_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h64; // d
      3'd1:    ch = 8'h61; // a
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h61; // a
      3'd4:    ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h3B; // ;
      3'd1:    ch = 8'h62; // b
      3'd2:    ch = 8'h61; // a
      3'd3:    ch = 8'h73; // s
      3'd4:    ch = 8'h65; // e
      3'd5:    ch = 8'h36; // 6
      3'd6:    ch = 8'h34; // 4
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_b64_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // returns {valid, value}
  function automatic logic [6:0] b64_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // returns {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h41 + 8'd10;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/dupd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_front
// Accepts URI characters, tracks prefix / metadata / payload parsing and
// turns each character into a bundle of result items for the queue.
// ----------------------------------------------------------------------------
module dupd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       in_char,
  input  wire logic             in_is_last,
  output dupd_pkg::bundle_t     bundle,
  output logic                  bundle_push
);

  dupd_pkg::phase_t     phase_r, phase_nxt;
  logic [2:0]           prefix_pos_r, prefix_pos_nxt;
  logic [2:0]           tag_match_r, tag_match_nxt;
  logic                 tag_found_r, tag_found_nxt;
  logic [11:0]          bit_acc_r, bit_acc_nxt;
  logic signed [3:0]    bit_count_r, bit_count_nxt;
  dupd_pkg::esc_stage_t esc_stage_r, esc_stage_nxt;
  logic [7:0]           esc_char_r, esc_char_nxt;
  logic [3:0]           esc_val_r, esc_val_nxt;
  logic [1:0]           error_r, error_nxt;

  logic [6:0]           b64_dec;
  logic [4:0]           hex_dec;
  logic [11:0]          acc_shift;
  logic signed [3:0]    cnt_add;
  logic [11:0]          acc_out;

  assign b64_dec   = dupd_pkg::b64_decode(in_char);
  assign hex_dec   = dupd_pkg::hex_decode(in_char);
  assign acc_shift = {bit_acc_r[5:0], b64_dec[5:0]};
  assign cnt_add   = bit_count_r + dupd_pkg::B64_BITS;
  assign acc_out   = acc_shift >> cnt_add[2:0];

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    prefix_pos_nxt = prefix_pos_r;
    tag_match_nxt  = tag_match_r;
    tag_found_nxt  = tag_found_r;
    bit_acc_nxt    = bit_acc_r;
    bit_count_nxt  = bit_count_r;
    esc_stage_nxt  = esc_stage_r;
    esc_char_nxt   = esc_char_r;
    esc_val_nxt    = esc_val_r;
    error_nxt      = error_r;
    case (phase_r)
      dupd_pkg::PH_PREFIX: begin
        if (prefix_pos_r < dupd_pkg::PREFIX_LEN &&
            in_char == dupd_pkg::prefix_char(prefix_pos_r)) begin
          prefix_pos_nxt = prefix_pos_r + 3'd1;
          if (prefix_pos_r == dupd_pkg::PREFIX_LEN - 3'd1) begin
            phase_nxt = dupd_pkg::PH_META;
          end
        end else begin
          error_nxt = dupd_pkg::ST_NO_PREFIX;
          phase_nxt = dupd_pkg::PH_SINK;
        end
      end
      dupd_pkg::PH_META: begin
        if (in_char == dupd_pkg::CH_COMMA) begin
          phase_nxt     = tag_found_r ? dupd_pkg::PH_B64 : dupd_pkg::PH_PCT;
          bit_acc_nxt   = '0;
          bit_count_nxt = dupd_pkg::BIT_CNT_INIT;
          esc_stage_nxt = dupd_pkg::ESC_NONE;
        end else if (!tag_found_r) begin
          if (tag_match_r < dupd_pkg::TAG_LEN &&
              in_char == dupd_pkg::tag_char(tag_match_r)) begin
            tag_match_nxt = tag_match_r + 3'd1;
          end else begin
            tag_match_nxt = (in_char == dupd_pkg::CH_SEMI) ? 3'd1 : 3'd0;
          end
          if (tag_match_nxt == dupd_pkg::TAG_LEN) begin
            tag_found_nxt = 1'b1;
          end
        end
      end
      dupd_pkg::PH_B64: begin
        if (dupd_pkg::is_b64_space(in_char)) begin
          phase_nxt = phase_r;
        end else if (in_char == dupd_pkg::CH_EQUAL) begin
          phase_nxt = dupd_pkg::PH_B64_END;
        end else if (!b64_dec[6]) begin
          error_nxt = dupd_pkg::ST_BAD_B64;
          phase_nxt = dupd_pkg::PH_SINK;
        end else begin
          bit_acc_nxt   = acc_shift;
          bit_count_nxt = cnt_add[3] ? cnt_add : cnt_add - dupd_pkg::BYTE_BITS;
        end
      end
      dupd_pkg::PH_PCT: begin
        case (esc_stage_r)
          dupd_pkg::ESC_PCT: begin
            if (hex_dec[4]) begin
              esc_char_nxt  = in_char;
              esc_val_nxt   = hex_dec[3:0];
              esc_stage_nxt = dupd_pkg::ESC_DIGIT;
            end else begin
              esc_stage_nxt = (in_char == dupd_pkg::CH_PERCENT) ?
                              dupd_pkg::ESC_PCT : dupd_pkg::ESC_NONE;
            end
          end
          dupd_pkg::ESC_DIGIT: begin
            if (hex_dec[4]) begin
              esc_stage_nxt = dupd_pkg::ESC_NONE;
            end else begin
              esc_stage_nxt = (in_char == dupd_pkg::CH_PERCENT) ?
                              dupd_pkg::ESC_PCT : dupd_pkg::ESC_NONE;
            end
          end
          default: begin
            esc_stage_nxt = (in_char == dupd_pkg::CH_PERCENT) ?
                            dupd_pkg::ESC_PCT : dupd_pkg::ESC_NONE;
          end
        endcase
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // result bundle for the current character
  always_comb begin
    logic [1:0]      nb;
    logic [2:0][7:0] bb;
    nb = 2'd0;
    bb = '0;
    case (phase_r)
      dupd_pkg::PH_B64: begin
        if (!dupd_pkg::is_b64_space(in_char) && in_char != dupd_pkg::CH_EQUAL &&
            b64_dec[6] && !cnt_add[3]) begin
          bb[nb] = acc_out[7:0];
          nb     = nb + 2'd1;
        end
      end
      dupd_pkg::PH_PCT: begin
        case (esc_stage_r)
          dupd_pkg::ESC_PCT: begin
            if (!hex_dec[4]) begin
              bb[nb] = dupd_pkg::CH_PERCENT;
              nb     = nb + 2'd1;
              if (in_char != dupd_pkg::CH_PERCENT) begin
                bb[nb] = in_char;
                nb     = nb + 2'd1;
              end
            end
          end
          dupd_pkg::ESC_DIGIT: begin
            if (hex_dec[4]) begin
              bb[nb] = {esc_val_r, hex_dec[3:0]};
              nb     = nb + 2'd1;
            end else begin
              bb[nb] = dupd_pkg::CH_PERCENT;
              nb     = nb + 2'd1;
              bb[nb] = esc_char_r;
              nb     = nb + 2'd1;
              if (in_char != dupd_pkg::CH_PERCENT) begin
                bb[nb] = in_char;
                nb     = nb + 2'd1;
              end
            end
          end
          default: begin
            if (in_char != dupd_pkg::CH_PERCENT) begin
              bb[nb] = in_char;
              nb     = nb + 2'd1;
            end
          end
        endcase
      end
      default: begin
        nb = 2'd0;
      end
    endcase
    // flush an escape cut off by the end of the uri
    if (in_is_last && phase_nxt == dupd_pkg::PH_PCT) begin
      if (esc_stage_nxt == dupd_pkg::ESC_PCT || esc_stage_nxt == dupd_pkg::ESC_DIGIT) begin
        bb[nb] = dupd_pkg::CH_PERCENT;
        nb     = nb + 2'd1;
      end
      if (esc_stage_nxt == dupd_pkg::ESC_DIGIT) begin
        bb[nb] = esc_char_nxt;
        nb     = nb + 2'd1;
      end
    end
    bundle.nbytes     = nb;
    bundle.bytes      = bb;
    bundle.has_status = in_is_last;
    case (phase_nxt)
      dupd_pkg::PH_PREFIX: bundle.status = dupd_pkg::ST_NO_PREFIX;
      dupd_pkg::PH_META:   bundle.status = dupd_pkg::ST_NO_COMMA;
      default:             bundle.status = error_nxt;
    endcase
    bundle_push = accept && ((nb != 2'd0) || in_is_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dupd_pkg::PH_PREFIX;
      prefix_pos_r <= '0;
      tag_match_r  <= '0;
      tag_found_r  <= 1'b0;
      bit_acc_r    <= '0;
      bit_count_r  <= dupd_pkg::BIT_CNT_INIT;
      esc_stage_r  <= dupd_pkg::ESC_NONE;
      error_r      <= dupd_pkg::ST_OK;
    end else if (accept) begin
      if (in_is_last) begin
        // uri closed: back to the start state
        phase_r      <= dupd_pkg::PH_PREFIX;
        prefix_pos_r <= '0;
        tag_match_r  <= '0;
        tag_found_r  <= 1'b0;
        bit_acc_r    <= '0;
        bit_count_r  <= dupd_pkg::BIT_CNT_INIT;
        esc_stage_r  <= dupd_pkg::ESC_NONE;
        error_r      <= dupd_pkg::ST_OK;
      end else begin
        phase_r      <= phase_nxt;
        prefix_pos_r <= prefix_pos_nxt;
        tag_match_r  <= tag_match_nxt;
        tag_found_r  <= tag_found_nxt;
        bit_acc_r    <= bit_acc_nxt;
        bit_count_r  <= bit_count_nxt;
        esc_stage_r  <= esc_stage_nxt;
        error_r      <= error_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      esc_char_r <= esc_char_nxt;
      esc_val_r  <= esc_val_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/dupd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_queue
// Small register queue of result bundles between parser and output side.
// ----------------------------------------------------------------------------
module dupd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire dupd_pkg::bundle_t push_data,
  input  wire logic              pop,
  output dupd_pkg::bundle_t      head,
  output logic                   empty,
  output logic                   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dupd_pkg::bundle_t  entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/dupd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dupd_back
// Walks each queued bundle one result item at a time into the output
// register.
// ----------------------------------------------------------------------------
module dupd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dupd_pkg::bundle_t head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic                   out_end_of_uri,
  output logic [1:0]             out_status
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       eou_r, eou_nxt;
  logic [1:0] status_r, status_nxt;

  logic       load;
  logic [2:0] total;
  logic       is_byte;

  assign total   = {1'b0, head.nbytes} + {2'b00, head.has_status};
  assign is_byte = (idx_r < head.nbytes);
  assign load    = (!valid_r || out_ready) && !empty;
  assign pop     = load && ({1'b0, idx_r} + 3'd1 == total);

  always_comb begin
    idx_nxt    = idx_r;
    valid_nxt  = valid_r && !out_ready;
    byte_nxt   = byte_r;
    bvalid_nxt = bvalid_r;
    eou_nxt    = eou_r;
    status_nxt = status_r;
    if (load) begin
      valid_nxt  = 1'b1;
      idx_nxt    = pop ? 2'd0 : idx_r + 2'd1;
      byte_nxt   = is_byte ? head.bytes[idx_r] : 8'h00;
      bvalid_nxt = is_byte;
      eou_nxt    = !is_byte;
      status_nxt = is_byte ? dupd_pkg::ST_OK : head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    eou_r    <= eou_nxt;
    status_r <= status_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_end_of_uri = eou_r;
  assign out_status     = status_r;

endmodule
`default_nettype wire

/* rtl/data_uri_payload_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// data_uri_payload_decoder_unit
// Streaming decoder for data: URIs, base64 or percent-escaped payloads.
// ----------------------------------------------------------------------------
// One character is taken every cycle while the result queue has room; the
// parser turns it into a bundle of zero to four result items (decoded bytes,
// plus the status item on the last character) in the same cycle. The output
// side delivers one result item per cycle while out_ready is high, from a
// registered output stage; a character yielding several items (a malformed
// escape, or the last character with its status item and any flushed escape)
// holds the output until all its items are out. The QUEUE_DEPTH-bundle queue
// absorbs these bursts and output stalls before the input sees backpressure.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_end_of_uri,
  output logic [1:0]      out_status
);

  dupd_pkg::bundle_t bundle;
  dupd_pkg::bundle_t head;
  logic              bundle_push;
  logic              q_empty;
  logic              q_full;
  logic              q_pop;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  dupd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_char     (in_char),
    .in_is_last  (in_is_last),
    .bundle      (bundle),
    .bundle_push (bundle_push)
  );

  dupd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (bundle_push),
    .push_data (bundle),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dupd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_end_of_uri (out_end_of_uri),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire
